### hdl/assert_macros.svh
// Assertion macros used by the checker file of the scan core.
// Needs a clock at the place of use, and an active-low reset for MBPS_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define MBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scan core assertion failed");

// Clocked assertion that also holds through reset.
`define MBPS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scan core assertion failed");

`endif

### hdl/mbps_pkg.sv
// Types and constants of the masked byte pattern scan core.
// No dependencies.
package mbps_pkg;

  localparam int ADDR_W      = 48;
  localparam int PAT_REG_W   = 64;
  localparam int PAT_BYTES   = 24;
  localparam int MASK_W      = 24;
  localparam int LEN_W       = 5;
  localparam int RANK_W      = 16;
  localparam int TOTAL_W     = 16;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 6;
  localparam int REG_IDX_W   = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SECTION_BASE  = 3'd0,
    REG_PATTERN_LOW   = 3'd1,
    REG_PATTERN_MID   = 3'd2,
    REG_PATTERN_HIGH  = 3'd3,
    REG_CARE_MASK     = 3'd4,
    REG_PATTERN_LEN   = 3'd5,
    REG_MATCH_RANK    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [ADDR_W-1:0]  match_address;
    logic [TOTAL_W-1:0] match_total;
    logic               pattern_rejected;
  } out_item_t;

  typedef struct packed {
    logic match;
    logic rejected;
  } chain_status_t;

endpackage

### hdl/mbps_cell.sv
// One window cell: holds one byte, passes it on, compares it with its pattern byte.
// Depends on nothing but its ports.
module mbps_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic       care,
  output logic [7:0] byte_out,
  output logic       pass
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign pass     = !care || (byte_r == pat_byte);

endmodule

### hdl/mbps_chain.sv
// Row of window cells with pattern alignment and the match reduction.
// Uses mbps_pkg and mbps_cell.
module mbps_chain
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = 24
) (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [7:0]                 byte_in,
  input  logic [PAT_BYTES-1:0][7:0]  pattern,
  input  logic [MASK_W-1:0]          care_mask,
  input  logic [LEN_W-1:0]           len_eff,
  output chain_status_t              status
);

  logic [MAX_PATTERN_LEN:0][7:0]   link;
  logic [MAX_PATTERN_LEN-1:0]      pass;
  logic [MAX_PATTERN_LEN-1:0]      care;

  assign link[0] = byte_in;

  // cell j holds the byte of age j; it lines up with pattern byte len-1-j
  for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_cell
    logic [LEN_W-1:0] pidx;
    logic             in_use;

    assign in_use  = LEN_W'(j) < len_eff;
    assign pidx    = in_use ? (len_eff - LEN_W'(j) - LEN_W'(1)) : '0;
    assign care[j] = in_use && care_mask[pidx];

    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (link[j]),
      .pat_byte (pattern[pidx]),
      .care     (care[j]),
      .byte_out (link[j+1]),
      .pass     (pass[j])
    );
  end

  assign status.match    = &pass;
  assign status.rejected = !(|care);

endmodule

### hdl/masked_byte_pattern_scan_core.sv
// Masked byte pattern scan core: one byte per cycle through a row of window cells.
// Section result path: front stage registers, then the output register.
// Throughput: one byte per cycle; input stalls only while a section result waits
// behind an output result that has not been taken.
// Reset (synchronous, rst_n low): registers to their reset values, scan state cleared.
// Uses mbps_pkg and mbps_chain.
module masked_byte_pattern_scan_core
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = 24,
  parameter int OFFSET_WIDTH    = 32,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CMP_W = (COUNT_WIDTH > RANK_W) ? COUNT_WIDTH : RANK_W;
  localparam logic [CMP_W-1:0] TOTAL_MAX = CMP_W'({TOTAL_W{1'b1}});

  logic [ADDR_W-1:0]    section_base_r;
  logic [PAT_REG_W-1:0] pat_low_r;
  logic [PAT_REG_W-1:0] pat_mid_r;
  logic [PAT_REG_W-1:0] pat_high_r;
  logic [MASK_W-1:0]    care_mask_r;
  logic [LEN_W-1:0]     pattern_len_r;
  logic [RANK_W-1:0]    match_rank_r;

  logic                 cfg_wr;
  reg_idx_t             reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_base_r <= '0;
      pat_low_r      <= '0;
      pat_mid_r      <= '0;
      pat_high_r     <= '0;
      care_mask_r    <= '0;
      pattern_len_r  <= LEN_W'(1);
      match_rank_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SECTION_BASE: section_base_r <= pwdata[ADDR_W-1:0];
        REG_PATTERN_LOW:  pat_low_r      <= pwdata;
        REG_PATTERN_MID:  pat_mid_r      <= pwdata;
        REG_PATTERN_HIGH: pat_high_r     <= pwdata;
        REG_CARE_MASK:    care_mask_r    <= pwdata[MASK_W-1:0];
        REG_PATTERN_LEN:  pattern_len_r  <= pwdata[LEN_W-1:0];
        REG_MATCH_RANK:   match_rank_r   <= pwdata[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SECTION_BASE: prdata = APB_DATA_W'(section_base_r);
      REG_PATTERN_LOW:  prdata = pat_low_r;
      REG_PATTERN_MID:  prdata = pat_mid_r;
      REG_PATTERN_HIGH: prdata = pat_high_r;
      REG_CARE_MASK:    prdata = APB_DATA_W'(care_mask_r);
      REG_PATTERN_LEN:  prdata = APB_DATA_W'(pattern_len_r);
      REG_MATCH_RANK:   prdata = APB_DATA_W'(match_rank_r);
      default:          prdata = '0;
    endcase
  end

  logic [LEN_W-1:0] len_eff;

  always_comb begin
    if (pattern_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_len_r > LEN_W'(MAX_PATTERN_LEN)) begin
      len_eff = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      len_eff = pattern_len_r;
    end
  end

  // pipeline control
  logic adv;
  logic accept;
  logic s1_valid_r;
  logic s1_last_r;
  logic s1_elig_r;
  logic [OFFSET_WIDTH-1:0] s1_ofs_r;
  logic out_valid_r;
  out_item_t out_data_r;

  assign adv      = !(s1_valid_r && s1_last_r && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // front stage: window shift and offset tracking
  logic [OFFSET_WIDTH-1:0] offset_r;
  logic                    offset_sat;
  logic                    elig;
  logic [OFFSET_WIDTH-1:0] start_ofs;

  assign offset_sat = &offset_r;
  assign elig       = !offset_sat &&
                      (({1'b0, offset_r} + (OFFSET_WIDTH+1)'(1)) >=
                       (OFFSET_WIDTH+1)'(len_eff));
  assign start_ofs  = offset_r + OFFSET_WIDTH'(1) - OFFSET_WIDTH'(len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        if (in_data.last_byte) begin
          offset_r <= '0;
        end else if (!offset_sat) begin
          offset_r <= offset_r + OFFSET_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_data.last_byte;
      s1_elig_r <= elig;
      s1_ofs_r  <= start_ofs;
    end
  end

  chain_status_t chain_status;

  mbps_chain #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_chain (
    .clk       (clk),
    .shift_en  (accept),
    .byte_in   (in_data.data_byte),
    .pattern   ({pat_high_r, pat_mid_r, pat_low_r}),
    .care_mask (care_mask_r),
    .len_eff   (len_eff),
    .status    (chain_status)
  );

  // back stage: tally, pick the ranked match, emit on the final byte
  logic [COUNT_WIDTH-1:0]  hit_count_r;
  logic [COUNT_WIDTH-1:0]  hit_count_upd;
  logic                    chosen_valid_r;
  logic                    chosen_valid_upd;
  logic [OFFSET_WIDTH-1:0] chosen_ofs_r;
  logic [OFFSET_WIDTH-1:0] chosen_ofs_upd;
  logic                    hit;
  logic                    s1_fire;
  out_item_t               result;

  assign hit     = s1_elig_r && chain_status.match;
  assign s1_fire = adv && s1_valid_r;

  always_comb begin
    hit_count_upd    = hit_count_r;
    chosen_valid_upd = chosen_valid_r;
    chosen_ofs_upd   = chosen_ofs_r;
    if (hit) begin
      if (!chosen_valid_r && (CMP_W'(hit_count_r) == CMP_W'(match_rank_r))) begin
        chosen_valid_upd = 1'b1;
        chosen_ofs_upd   = s1_ofs_r;
      end
      if (!(&hit_count_r)) begin
        hit_count_upd = hit_count_r + COUNT_WIDTH'(1);
      end
    end
  end

  always_comb begin
    result.pattern_rejected = chain_status.rejected;
    result.found            = !chain_status.rejected && chosen_valid_upd;
    result.match_address    = result.found ?
                              (section_base_r + ADDR_W'(chosen_ofs_upd)) : '0;
    if (chain_status.rejected) begin
      result.match_total = '0;
    end else if (CMP_W'(hit_count_upd) > TOTAL_MAX) begin
      result.match_total = '1;
    end else begin
      result.match_total = TOTAL_W'(hit_count_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_count_r    <= '0;
      chosen_valid_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        hit_count_r    <= '0;
        chosen_valid_r <= 1'b0;
      end else begin
        hit_count_r    <= hit_count_upd;
        chosen_valid_r <= chosen_valid_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      chosen_ofs_r <= chosen_ofs_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/mbps_checker.sv
// Port-level checks of the scan core result channel, bound to the top level.
// Uses mbps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbps_checker
  import mbps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `MBPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `MBPS_ASSERT(a_reject_zero, clk, rst_n, out_valid && out_data.pattern_rejected |-> !out_data.found && out_data.match_address == '0 && out_data.match_total == '0)
  `MBPS_ASSERT(a_miss_addr, clk, rst_n, out_valid && !out_data.found |-> out_data.match_address == '0)
  `MBPS_ASSERT(a_found_count, clk, rst_n, out_valid && out_data.found |-> out_data.match_total != '0)
  `MBPS_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind masked_byte_pattern_scan_core mbps_checker u_mbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### bench/masked_byte_pattern_scan_core_tb.sv
// Self-checking bench for masked_byte_pattern_scan_core: section bytes stream in, section
// reports are predicted per accepted byte and compared field by field as they come out.
// Depends on mbps_pkg and the scan core RTL.
module masked_byte_pattern_scan_core_tb;
  import mbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_W     = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 780;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  masked_byte_pattern_scan_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copies
  logic [ADDR_W-1:0]    base_addr = '0;
  logic [PAT_REG_W-1:0] pat_low = '0;
  logic [PAT_REG_W-1:0] pat_mid = '0;
  logic [PAT_REG_W-1:0] pat_high = '0;
  logic [MASK_W-1:0]    care_mask = '0;
  logic [LEN_W-1:0]     pat_len = LEN_W'(1);
  logic [RANK_W-1:0]    rank_sel = '0;

  // scan state
  logic [7:0]          win_bytes [PAT_BYTES];
  logic [OFFSET_W-1:0] sec_offset = '0;
  logic [TOTAL_W-1:0]  hit_total = '0;
  logic [OFFSET_W-1:0] pick_offset = '0;
  logic                pick_seen = 1'b0;

  in_item_t    byte_stream [$];
  out_item_t   section_reports [$];
  out_item_t   want;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_run = 0;
  int unsigned stall_run = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_length();
    if (pat_len == 0) return 1;
    if (pat_len > PAT_BYTES) return PAT_BYTES;
    return pat_len;
  endfunction

  function automatic void scan_byte(input in_item_t txn);
    int unsigned         len;
    logic                rejected;
    logic                hit;
    logic [191:0]        pat;
    out_item_t           res;
    len = eff_length();
    pat = {pat_high, pat_mid, pat_low};
    rejected = 1'b1;
    for (int k = 0; k < len; k++) if (care_mask[k]) rejected = 1'b0;
    for (int k = 0; k < PAT_BYTES - 1; k++) win_bytes[k] = win_bytes[k + 1];
    win_bytes[PAT_BYTES - 1] = txn.data_byte;
    if (sec_offset != '1) begin
      if ({1'b0, sec_offset} + 33'd1 >= 33'(len)) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++)
          if (care_mask[k] && win_bytes[PAT_BYTES - len + k] != pat[8*k +: 8]) hit = 1'b0;
        if (hit) begin
          if (!pick_seen && hit_total == rank_sel) begin
            pick_offset = sec_offset + OFFSET_W'(1) - OFFSET_W'(len);
            pick_seen = 1'b1;
          end
          if (hit_total != '1) hit_total = hit_total + 1'b1;
        end
      end
      sec_offset = sec_offset + 1'b1;
    end
    if (txn.last_byte) begin
      if (rejected) begin
        res.found = 1'b0;
        res.match_address = '0;
        res.match_total = '0;
        res.pattern_rejected = 1'b1;
      end else begin
        res.found = pick_seen;
        res.match_address = pick_seen ? base_addr + {{(ADDR_W-OFFSET_W){1'b0}}, pick_offset} : '0;
        res.match_total = hit_total;
        res.pattern_rejected = 1'b0;
      end
      section_reports.insert(section_reports.size(), res);
      sec_offset = '0;
      hit_total = '0;
      pick_offset = '0;
      pick_seen = 1'b0;
    end
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_stream.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= byte_stream.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: ready runs alternating with stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
      out_ready <= 1'b1;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_ready <= 1'b0;
    end else begin
      ready_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
      stall_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      out_ready <= $urandom_range(0, 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (section_reports.size() == 0) begin
          if (error_count < 10)
            $display("unexpected report: found=%0d addr=%h total=%0d rejected=%0d",
                     out_data.found, out_data.match_address, out_data.match_total,
                     out_data.pattern_rejected);
          error_count++;
        end else begin
          want = section_reports.pop_front();
          if (out_data.found !== want.found ||
              out_data.match_address !== want.match_address ||
              out_data.match_total !== want.match_total ||
              out_data.pattern_rejected !== want.pattern_rejected) begin
            if (error_count < 10)
              $display("report mismatch: want found=%0d addr=%h total=%0d rejected=%0d, got found=%0d addr=%h total=%0d rejected=%0d",
                       want.found, want.match_address, want.match_total, want.pattern_rejected,
                       out_data.found, out_data.match_address, out_data.match_total,
                       out_data.pattern_rejected);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) scan_byte(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("masked_byte_pattern_scan_core test failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SECTION_BASE: base_addr = value[ADDR_W-1:0];
      REG_PATTERN_LOW:  pat_low = value;
      REG_PATTERN_MID:  pat_mid = value;
      REG_PATTERN_HIGH: pat_high = value;
      REG_CARE_MASK:    care_mask = value[MASK_W-1:0];
      REG_PATTERN_LEN:  pat_len = value[LEN_W-1:0];
      REG_MATCH_RANK:   rank_sel = value[RANK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (byte_stream.size() != 0 || in_valid || section_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    in_item_t txn;
    txn.data_byte = data;
    txn.last_byte = last;
    byte_stream.insert(byte_stream.size(), txn);
  endtask

  // planted: drop pattern copies into random bytes; alphabet: draw from pattern bytes
  task automatic queue_section(input int unsigned n_bytes, input int unsigned mode,
                               input logic close);
    logic [7:0]   sec [$];
    logic [191:0] pat;
    int unsigned  len;
    int unsigned  at;
    int unsigned  plants;
    pat = {pat_high, pat_mid, pat_low};
    len = eff_length();
    plants = (mode <= 5) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < n_bytes; i++) begin
      if (mode >= 6 && mode <= 7 && $urandom_range(0, 3) != 0)
        sec.insert(sec.size(), pat[8 * $urandom_range(0, len - 1) +: 8]);
      else
        sec.insert(sec.size(), 8'($urandom));
    end
    for (int p = 0; p < plants; p++) begin
      if (n_bytes >= len) begin
        at = $urandom_range(0, n_bytes - len);
        for (int k = 0; k < len; k++) if (care_mask[k]) sec[at + k] = pat[8*k +: 8];
      end
    end
    for (int i = 0; i < n_bytes; i++) queue_byte(sec[i], close && (i == n_bytes - 1));
  endtask

  function automatic logic [APB_DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic setup_random();
    logic [APB_DATA_W-1:0] w;
    write_reg(REG_SECTION_BASE, rand_word());
    write_reg(REG_PATTERN_LOW, rand_word());
    write_reg(REG_PATTERN_MID, rand_word());
    write_reg(REG_PATTERN_HIGH, rand_word());
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w[MASK_W-1:0] = '0;
      1, 2: w[MASK_W-1:0] = '1;
      3: w[MASK_W-1:0] = MASK_W'($urandom & $urandom);
      default: w[MASK_W-1:0] = MASK_W'($urandom);
    endcase
    write_reg(REG_CARE_MASK, w);
    w = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: w[LEN_W-1:0] = '0;
      1: w[LEN_W-1:0] = '1;
      2: w[LEN_W-1:0] = LEN_W'($urandom_range(25, 30));
      3, 4: w[LEN_W-1:0] = LEN_W'(1);
      5, 6: w[LEN_W-1:0] = LEN_W'(PAT_BYTES);
      default: w[LEN_W-1:0] = LEN_W'($urandom_range(2, 23));
    endcase
    write_reg(REG_PATTERN_LEN, w);
    w = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: w[RANK_W-1:0] = '1;
      1, 2, 3, 4: w[RANK_W-1:0] = '0;
      5, 6, 7, 8: w[RANK_W-1:0] = RANK_W'($urandom_range(1, 3));
      default: w[RANK_W-1:0] = RANK_W'($urandom_range(0, 15));
    endcase
    write_reg(REG_MATCH_RANK, w);
  endtask

  initial begin
    int unsigned random_bytes;
    int unsigned n_sec;
    int unsigned size;
    logic        open;
    random_bytes = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: every byte a wildcard
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hA5, 1'b1);
    wait_idle();

    // wildcard in the middle, second match picked, address wraps past the top
    write_reg(REG_SECTION_BASE, 64'h0000_FFFF_FFFF_FFFE);
    write_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_EF00_ADDE);
    write_reg(REG_PATTERN_MID, 64'h0);
    write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CARE_MASK, 64'h0B);
    write_reg(REG_PATTERN_LEN, 64'd4);
    write_reg(REG_MATCH_RANK, 64'd1);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b1);
    wait_idle();

    // zero length acts as one; care bits past the length are ignored
    write_reg(REG_PATTERN_LEN, 64'd0);
    write_reg(REG_CARE_MASK, 64'hFF_FFFE);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b1);
    wait_idle();

    // rank beyond the match count
    write_reg(REG_CARE_MASK, 64'hFF_FFFF);
    write_reg(REG_MATCH_RANK, 64'd5);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hDE, 1'b1);

    while (random_bytes < RANDOM_BYTES) begin
      wait_idle();
      setup_random();
      n_sec = $urandom_range(1, 4);
      for (int s = 0; s < n_sec; s++) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
        open = (s == n_sec - 1) && ($urandom_range(0, 5) == 0);
        queue_section(size, $urandom_range(0, 9), !open);
        random_bytes += size;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("masked_byte_pattern_scan_core test passed");
    end else begin
      $display("masked_byte_pattern_scan_core test failed");
    end
    $finish;
  end

endmodule
